>>> sv/additive_feedback_rng_core_defines.svh
// Assertion macros shared by the additive feedback generator RTL.
// Expects clk and rst (synchronous, active high) in the including scope.
`ifndef ADDITIVE_FEEDBACK_RNG_CORE_DEFINES_SVH
`define ADDITIVE_FEEDBACK_RNG_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define AFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define AFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/afr_pkg.sv
// Package for the additive feedback generator: widths, LCG constants and defaults.
// No dependencies.
`default_nettype none

package afr_pkg;

  // Table geometry defaults
  localparam int DEGREE_DEF     = 31;
  localparam int SEPARATION_DEF = 3;
  localparam int DISCARD_ROUNDS = 10;

  // Data widths
  localparam int WORD_W  = 32;
  localparam int VALUE_W = 31;
  localparam int MUL_W   = 15;
  localparam int PROD_W  = WORD_W + MUL_W;

  // Minimal-standard LCG: multiplier and modulus 2^31-1
  localparam logic [MUL_W-1:0]   LCG_MUL = 15'd16807;
  localparam logic [VALUE_W-1:0] LCG_MOD = 31'h7FFF_FFFF;

endpackage

`default_nettype wire

>>> sv/afr_lag_mem.sv
// Lag table storage: one write port, two registered read ports.
// Depends on afr_pkg for the word width.
`default_nettype none

module afr_lag_mem #(
  parameter int DEPTH = afr_pkg::DEGREE_DEF,
  parameter int AW    = $clog2(afr_pkg::DEGREE_DEF)
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [afr_pkg::WORD_W-1:0] wdata,
  input  wire logic [AW-1:0]              raddr_a,
  input  wire logic [AW-1:0]              raddr_b,
  output logic      [afr_pkg::WORD_W-1:0] rdata_a,
  output logic      [afr_pkg::WORD_W-1:0] rdata_b
);
  import afr_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

>>> sv/afr_lcg_unit.sv
// LCG step unit: 16807 * x mod (2^31-1), multiply registered, then fold and reduce.
// Depends on afr_pkg for the LCG constants.
`default_nettype none

module afr_lcg_unit (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic [afr_pkg::WORD_W-1:0]  operand,
  output logic      [afr_pkg::VALUE_W-1:0] residue
);
  import afr_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [WORD_W-1:0] fold_sum;
  logic [WORD_W-1:0] fold_red;

  // Product register; operand is a non-negative residue class below 2^32
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_W'(operand) * PROD_W'(LCG_MUL);
    end
  end

  // 2^31 = 1 mod m: fold the high part onto the low part, one subtract finishes
  always_comb begin
    fold_sum = WORD_W'(prod[PROD_W-1:VALUE_W]) + WORD_W'(prod[VALUE_W-1:0]);
    fold_red = fold_sum - WORD_W'(LCG_MOD);
    residue  = (fold_sum >= WORD_W'(LCG_MOD)) ? fold_red[VALUE_W-1:0]
                                               : fold_sum[VALUE_W-1:0];
  end

endmodule

`default_nettype wire

>>> sv/additive_feedback_rng_core.sv
// Additive lagged-Fibonacci generator top level: sequencer, adder, lag table, LCG unit.
// Depends on afr_pkg, afr_lag_mem, afr_lcg_unit and the assertion macro header.
//
//  channel   signals                        handshake
//  request   operation, seed                taken when start is high and busy is low
//  result    random_value                   valid high for one cycle, no back-pressure
//
// A draw keeps busy high through a registered table read, then an add and write
// back; its result shows in the cycle after. A reseed keeps busy high through the
// write of entry 0, one LCG step per entry through the shared multiply-reduce
// unit, then 10*DEGREE discarded additions. A draw before any seed runs that
// reseed first. Reset returns the indices to their start values and clears the
// seeded flag; the table holds no reset.
`default_nettype none
`include "additive_feedback_rng_core_defines.svh"

module additive_feedback_rng_core #(
  parameter int DEGREE     = afr_pkg::DEGREE_DEF,
  parameter int SEPARATION = afr_pkg::SEPARATION_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        operation,
  input  wire logic [afr_pkg::WORD_W-1:0]  seed,
  output logic                             valid,
  output logic      [afr_pkg::VALUE_W-1:0] random_value
);
  import afr_pkg::*;

  localparam int IW       = $clog2(DEGREE);
  localparam int DISCARDS = DISCARD_ROUNDS * DEGREE;
  localparam int CW       = $clog2(DISCARDS);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_RED  = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_ADD  = 3'd5;

  logic [2:0]         state;
  logic [IW-1:0]      front_idx;
  logic [IW-1:0]      rear_idx;
  logic [IW-1:0]      fill_idx;
  logic [CW-1:0]      discard_cnt;
  logic               seeded;
  logic               draw_pending;
  logic               discarding;
  logic [WORD_W-1:0]  seed_reg;
  logic [WORD_W-1:0]  lcg_word;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [WORD_W-1:0]  front_data;
  logic [WORD_W-1:0]  rear_data;
  logic [WORD_W-1:0]  sum;
  logic [VALUE_W-1:0] residue;
  logic               accept;

  logic [IW:0]        front_x;
  logic [IW:0]        rear_x;
  logic [IW:0]        sep_x;
  logic [IW:0]        deg_x;
  logic               gap_ok;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign sum    = front_data + rear_data;

  // Lag table
  afr_lag_mem #(
    .DEPTH (DEGREE),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (front_idx),
    .raddr_b (rear_idx),
    .rdata_a (front_data),
    .rdata_b (rear_data)
  );

  // Shared LCG multiply-reduce unit
  afr_lcg_unit u_lcg (
    .clk     (clk),
    .load    (state == ST_MUL),
    .operand (lcg_word),
    .residue (residue)
  );

  // Table write source
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = front_idx;
    mem_wdata = sum;
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = seed_reg;
      end
      ST_RED: begin
        mem_we    = 1'b1;
        mem_waddr = fill_idx;
        mem_wdata = WORD_W'(residue);
      end
      ST_ADD: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      front_idx    <= IW'(SEPARATION);
      rear_idx     <= '0;
      fill_idx     <= '0;
      discard_cnt  <= '0;
      seeded       <= 1'b0;
      draw_pending <= 1'b0;
      discarding   <= 1'b0;
      valid        <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (operation) begin
              seed_reg     <= (seed == '0) ? WORD_W'(1) : seed;
              draw_pending <= 1'b0;
              state        <= ST_INIT;
            end else if (seeded) begin
              draw_pending <= 1'b1;
              discarding   <= 1'b0;
              state        <= ST_RD;
            end else begin
              seed_reg     <= WORD_W'(1);
              draw_pending <= 1'b1;
              state        <= ST_INIT;
            end
          end
        end
        // entry 0 written; negative seed moved to its residue class (+2m)
        ST_INIT: begin
          seeded   <= 1'b1;
          lcg_word <= seed_reg[WORD_W-1] ? (seed_reg - WORD_W'(2)) : seed_reg;
          fill_idx <= IW'(1);
          state    <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_RED;
        end
        ST_RED: begin
          lcg_word <= WORD_W'(residue);
          if (fill_idx == IW'(DEGREE - 1)) begin
            front_idx   <= IW'(SEPARATION);
            rear_idx    <= '0;
            discard_cnt <= '0;
            discarding  <= 1'b1;
            state       <= ST_RD;
          end else begin
            fill_idx <= fill_idx + 1'b1;
            state    <= ST_MUL;
          end
        end
        ST_RD: begin
          state <= ST_ADD;
        end
        // sum written at the front; both indices step round the table
        ST_ADD: begin
          front_idx <= (front_idx == IW'(DEGREE - 1)) ? '0 : front_idx + 1'b1;
          rear_idx  <= (rear_idx == IW'(DEGREE - 1)) ? '0 : rear_idx + 1'b1;
          if (discarding) begin
            if (discard_cnt == CW'(DISCARDS - 1)) begin
              discarding <= 1'b0;
              state      <= draw_pending ? ST_RD : ST_IDLE;
            end else begin
              discard_cnt <= discard_cnt + 1'b1;
              state       <= ST_RD;
            end
          end else begin
            random_value <= sum[WORD_W-1:1];
            valid        <= 1'b1;
            draw_pending <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Front leads rear by the separation, round the table
  assign front_x = (IW+1)'(front_idx);
  assign rear_x  = (IW+1)'(rear_idx);
  assign sep_x   = (IW+1)'(SEPARATION);
  assign deg_x   = (IW+1)'(DEGREE);
  assign gap_ok  = ((front_x == rear_x + sep_x) || (front_x + deg_x == rear_x + sep_x))
                   && (rear_x < deg_x) && (front_x < deg_x);

  `AFR_ASSERT_NXT(a_strobe_single, valid, !valid, "result strobe held over a cycle")
  `AFR_ASSERT_IMP(a_strobe_idle, valid, !busy && !discarding, "result while still working")
  `AFR_ASSERT_NXT(a_accept_busy, accept, busy, "request taken but block not busy")
  `AFR_ASSERT_IMP(a_lag_gap, 1'b1, gap_ok, "front and rear indices out of step")

endmodule

`default_nettype wire

>>> tb/tb_additive_feedback_rng_core.sv
// Self-checking testbench for additive_feedback_rng_core: directed requests, then random ones.
// Each draw result is checked against a local lagged-Fibonacci model of the generator.
// Depends on afr_pkg and the core RTL only.
`default_nettype none

module tb_additive_feedback_rng_core;

  localparam int WORD_W  = afr_pkg::WORD_W;
  localparam int VALUE_W = afr_pkg::VALUE_W;
  localparam int DEGREE  = afr_pkg::DEGREE_DEF;
  localparam int SEP     = afr_pkg::SEPARATION_DEF;
  localparam int ROUNDS  = afr_pkg::DISCARD_ROUNDS;

  // Schrage factors of the minimal-standard LCG
  localparam longint LCG_A = 16807;
  localparam longint LCG_Q = 127773;
  localparam longint LCG_R = 2836;
  localparam longint LCG_M = 2147483647;

  // Request kinds
  localparam bit OP_DRAW = 1'b0;
  localparam bit OP_SEED = 1'b1;

  localparam int RAND_REQS  = 800;
  localparam int QUIET_REQS = 100;
  // settle time covers a whole reseed, with margin
  localparam int SETTLE     = 1 + 2 * (DEGREE - 1) + 20 * DEGREE + 20;
  localparam int CYCLE_CAP  = 2_000_000;

  // Directed row: request plus a hand-worked draw where one is obvious
  typedef struct packed {
    bit               op;
    bit [WORD_W-1:0]  sd;
    bit               pinned;
    bit [VALUE_W-1:0] val;
  } row_t;

  localparam int NROWS = 22;
  localparam row_t PLAN [NROWS] = '{
    {OP_DRAW, 32'h0000_0000, 1'b1, 31'd1804289383},  // draw before any seed
    {OP_DRAW, 32'hFFFF_FFFF, 1'b1, 31'd846930886},
    {OP_DRAW, 32'h1234_5678, 1'b1, 31'd1681692777},
    {OP_SEED, 32'h0000_0000, 1'b0, 31'd0},           // zero seed acts as one
    {OP_DRAW, 32'h0000_0000, 1'b1, 31'd1804289383},
    {OP_DRAW, 32'h0000_0000, 1'b1, 31'd846930886},
    {OP_SEED, 32'h0000_0001, 1'b0, 31'd0},
    {OP_DRAW, 32'hFFFF_FFFF, 1'b1, 31'd1804289383},
    {OP_SEED, 32'hFFFF_FFFF, 1'b0, 31'd0},           // negative seed
    {OP_DRAW, 32'h0000_0000, 1'b0, 31'd0},
    {OP_DRAW, 32'h0000_0000, 1'b0, 31'd0},
    {OP_SEED, 32'h8000_0000, 1'b0, 31'd0},           // most negative
    {OP_DRAW, 32'h0000_0000, 1'b0, 31'd0},
    {OP_SEED, 32'h7FFF_FFFF, 1'b0, 31'd0},           // largest positive
    {OP_DRAW, 32'h0000_0000, 1'b0, 31'd0},
    {OP_SEED, 32'd127773,    1'b0, 31'd0},           // exactly one Schrage quotient
    {OP_DRAW, 32'h0000_0000, 1'b0, 31'd0},
    {OP_SEED, 32'hAAAA_AAAA, 1'b0, 31'd0},           // back-to-back reseeds
    {OP_SEED, 32'h5555_5555, 1'b0, 31'd0},
    {OP_DRAW, 32'hFFFF_FFFF, 1'b0, 31'd0},
    {OP_DRAW, 32'h0000_0000, 1'b0, 31'd0},
    {OP_DRAW, 32'hFFFF_FFFF, 1'b0, 31'd0}
  };

  typedef struct {
    bit [VALUE_W-1:0] val;
    bit               pinned;
    bit [VALUE_W-1:0] pin;
  } draw_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               operation = OP_DRAW;
  logic [WORD_W-1:0]  seed = '0;
  logic               valid;
  logic [VALUE_W-1:0] random_value;

  // side-band for hand-worked rows, sampled with the request
  bit                 pin_on = 1'b0;
  bit [VALUE_W-1:0]   pin_val = '0;

  // model state
  bit [WORD_W-1:0]    taps [DEGREE];
  bit [4:0]           head_ix = 5'(SEP);
  bit [4:0]           tail_ix = '0;
  bit                 primed = 1'b0;

  draw_t              pending_draws [$];
  int                 taken = 0;
  int                 errors = 0;
  int                 cycles = 0;

  additive_feedback_rng_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .seed         (seed),
    .valid        (valid),
    .random_value (random_value)
  );

  always #4 clk = ~clk;

  // One additive feedback step: front += rear, both indices wrap at DEGREE
  function automatic bit [WORD_W-1:0] fib_step();
    bit [WORD_W-1:0] sum;
    sum = taps[head_ix] + taps[tail_ix];
    taps[head_ix] = sum;
    head_ix = (head_ix == 5'(DEGREE - 1)) ? '0 : head_ix + 5'd1;
    tail_ix = (tail_ix == 5'(DEGREE - 1)) ? '0 : tail_ix + 5'd1;
    return sum;
  endfunction

  // Table load from the LCG, then the warm-up discards
  function automatic void fib_reseed(bit [WORD_W-1:0] s);
    longint w;
    longint hi;
    longint lo;
    if (s == '0) s = 32'd1;
    taps[0] = s;
    w = longint'($signed(s));
    for (int i = 1; i < DEGREE; i++) begin
      hi = w / LCG_Q;
      lo = w % LCG_Q;
      w = LCG_A * lo - LCG_R * hi;
      if (w < 0) w += LCG_M;
      taps[i] = w[WORD_W-1:0];
    end
    head_ix = 5'(SEP);
    tail_ix = '0;
    primed = 1'b1;
    repeat (ROUNDS * DEGREE) void'(fib_step());
  endfunction

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Request capture and result check, all on the rising edge
  always @(posedge clk) begin
    draw_t d;
    bit [WORD_W-1:0] sum;
    if (!rst) begin
      if (start && !busy) begin
        taken++;
        if (operation == OP_SEED) begin
          fib_reseed(seed);
        end else begin
          if (!primed) fib_reseed(32'd1);
          sum = fib_step();
          d.val = sum[WORD_W-1:1];
          d.pinned = pin_on;
          d.pin = pin_val;
          pending_draws.push_back(d);
        end
      end
      if (valid) begin
        if (pending_draws.size() == 0) begin
          errors++;
          if (errors <= 10) $display("mismatch: unexpected result %0d", random_value);
        end else begin
          d = pending_draws.pop_front();
          if (random_value !== d.val || (d.pinned && random_value !== d.pin)) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: random_value expected %0d (known %0d, %0b) got %0d",
                       d.val, d.pin, d.pinned, random_value);
          end
        end
      end
    end
  end

  // Present one request at a falling edge and hold it until taken
  task automatic send(bit op, bit [WORD_W-1:0] sd, bit pinned, bit [VALUE_W-1:0] pv);
    int n;
    n = taken;
    start <= 1'b1;
    operation <= op;
    seed <= sd;
    pin_on <= pinned;
    pin_val <= pv;
    do @(negedge clk); while (taken == n);
  endtask

  task automatic hold_off();
    start <= 1'b0;
    repeat ($urandom_range(1, 3)) @(negedge clk);
  endtask

  // Stop sending until every outstanding draw has come back
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending_draws.size() != 0);
  endtask

  initial begin
    bit               op;
    bit [WORD_W-1:0]  sd;
    bit               quiet;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed rows
    for (int i = 0; i < NROWS; i++) begin
      if ($urandom_range(0, 2) == 0) hold_off();
      send(PLAN[i].op, PLAN[i].sd, PLAN[i].pinned, PLAN[i].val);
    end
    drain();

    // random requests: mostly draws, occasional reseeds with varied seeds
    for (int k = 0; k < RAND_REQS; k++) begin
      quiet = (k >= RAND_REQS - QUIET_REQS);
      if (k == RAND_REQS / 2) drain();
      else if (!quiet && $urandom_range(0, 3) == 0) hold_off();
      op = ($urandom_range(0, 31) == 0) ? OP_SEED : OP_DRAW;
      case ($urandom_range(0, 7))
        0:       sd = '0;
        1:       sd = 32'($urandom_range(1, 16));
        2:       sd = {1'b1, 31'($urandom)};
        3:       sd = 32'hFFFF_FFFF - 32'($urandom_range(0, 16));
        default: sd = $urandom;
      endcase
      send(op, sd, 1'b0, '0);
    end

    drain();
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
